// File: hdl/ccfw_pkg.sv
// Package with the shared types, codes and constants of the configurable cache.
package ccfw_pkg;

  localparam int CACHE_WORDS_DEF     = 256;
  localparam int MEM_WORDS_DEF       = 4096;
  localparam int MAX_BLOCK_WORDS_DEF = 16;
  localparam int WORD_BITS_DEF       = 32;

  localparam int ADDR_W  = 12;
  localparam int KIND_W  = 2;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 4;
  localparam int CFG_I_W = 3;

  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_INVAL = 2'd3;

  localparam logic [1:0] MAP_SET  = 2'd1;
  localparam logic [1:0] MAP_FULL = 2'd2;

  localparam logic WP_BACK = 1'b1;

  localparam logic [CFG_I_W-1:0] CFG_MAPPING = 3'd0;
  localparam logic [CFG_I_W-1:0] CFG_POLICY  = 3'd1;
  localparam logic [CFG_I_W-1:0] CFG_CACHE   = 3'd2;
  localparam logic [CFG_I_W-1:0] CFG_BLOCK   = 3'd3;
  localparam logic [CFG_I_W-1:0] CFG_WAYS    = 3'd4;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISP, ST_TAG_RD, ST_TAG_CMP, ST_FIFO_RD, ST_VICTIM,
    ST_WB_RD, ST_WB_WR, ST_FILL_RD, ST_FILL_WR, ST_SET_LINE, ST_FQ_RD, ST_FQ_WR,
    ST_FQ_LAST, ST_ACC, ST_FL_CHK, ST_FL_NEXT, ST_INV, ST_RESULT
  } st_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLR, CMD_LOAD, CMD_TAG_RD, CMD_TAG_CMP, CMD_FIFO_RD, CMD_VICTIM,
    CMD_WB_RD, CMD_WB_WR, CMD_FILL_RD, CMD_FILL_WR, CMD_SET_LINE, CMD_FQ_RD,
    CMD_FQ_WR, CMD_FQ_LAST, CMD_ACC, CMD_FL_CHK, CMD_FL_NEXT, CMD_INV, CMD_RESULT
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              wb;
    logic              match;
    logic              way_last;
    logic              inv_any;
    logic              word_last;
    logic              q_last;
    logic              ways_one;
    logic              dirty_cur;
    logic              line_last;
    logic              clr_last;
    logic              out_free;
  } stat_t;

endpackage

// File: hdl/ccfw_ctrl.sv
// Controller state machine that sequences the reset clear, lookups, fills, write-backs, flushes and invalidates.
module ccfw_ctrl
  import ccfw_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t sts,
  output cmd_t  cmd
);

  st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd = CMD_CLR;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd       = CMD_LOAD;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        if (sts.kind inside {KIND_READ, KIND_WRITE}) state_nxt = ST_TAG_RD;
        else if (sts.kind == KIND_FLUSH) state_nxt = sts.wb ? ST_FL_CHK : ST_RESULT;
        else state_nxt = ST_INV;
      end
      ST_TAG_RD: begin
        cmd       = CMD_TAG_RD;
        state_nxt = ST_TAG_CMP;
      end
      ST_TAG_CMP: begin
        cmd = CMD_TAG_CMP;
        if (sts.match) state_nxt = ST_ACC;
        else if (sts.way_last) state_nxt = sts.inv_any ? ST_FILL_RD : ST_FIFO_RD;
        else state_nxt = ST_TAG_RD;
      end
      ST_FIFO_RD: begin
        cmd       = CMD_FIFO_RD;
        state_nxt = ST_VICTIM;
      end
      ST_VICTIM: begin
        cmd       = CMD_VICTIM;
        state_nxt = sts.wb ? ST_WB_RD : ST_FILL_RD;
      end
      ST_WB_RD: begin
        cmd       = CMD_WB_RD;
        state_nxt = ST_WB_WR;
      end
      ST_WB_WR: begin
        cmd = CMD_WB_WR;
        if (sts.word_last) state_nxt = (sts.kind == KIND_FLUSH) ? ST_FL_NEXT : ST_FILL_RD;
        else state_nxt = ST_WB_RD;
      end
      ST_FILL_RD: begin
        cmd       = CMD_FILL_RD;
        state_nxt = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        cmd       = CMD_FILL_WR;
        state_nxt = sts.word_last ? ST_SET_LINE : ST_FILL_RD;
      end
      ST_SET_LINE: begin
        cmd       = CMD_SET_LINE;
        state_nxt = sts.ways_one ? ST_FQ_LAST : ST_FQ_RD;
      end
      ST_FQ_RD: begin
        cmd       = CMD_FQ_RD;
        state_nxt = ST_FQ_WR;
      end
      ST_FQ_WR: begin
        cmd       = CMD_FQ_WR;
        state_nxt = sts.q_last ? ST_FQ_LAST : ST_FQ_RD;
      end
      ST_FQ_LAST: begin
        cmd       = CMD_FQ_LAST;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd       = CMD_ACC;
        state_nxt = ST_RESULT;
      end
      ST_FL_CHK: begin
        cmd       = CMD_FL_CHK;
        state_nxt = sts.dirty_cur ? ST_WB_RD : ST_FL_NEXT;
      end
      ST_FL_NEXT: begin
        cmd       = CMD_FL_NEXT;
        state_nxt = sts.line_last ? ST_RESULT : ST_FL_CHK;
      end
      ST_INV: begin
        cmd       = CMD_INV;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd       = CMD_RESULT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_clear_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && !sts.clr_last) |=> state_r == ST_CLEAR)
    else $error("clearing pass left early");

  a_victim_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIFO_RD |-> $past(state_r == ST_TAG_CMP && !sts.inv_any))
    else $error("eviction with a free way");

  a_result_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT && !sts.out_free) |=> state_r == ST_RESULT)
    else $error("result dropped while output busy");

endmodule

// File: hdl/ccfw_dp.sv
// Datapath with configuration, tag, line, queue and backing memories and counters.
module ccfw_dp
  import ccfw_pkg::*;
#(
  parameter int CACHE_WORDS     = CACHE_WORDS_DEF,
  parameter int MEM_WORDS       = MEM_WORDS_DEF,
  parameter int MAX_BLOCK_WORDS = MAX_BLOCK_WORDS_DEF,
  parameter int WORD_BITS       = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_I_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic [WORD_BITS-1:0] in_write_data,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [WORD_BITS-1:0] out_read_data,
  output logic                 out_hit,
  output logic [CNT_W-1:0]     out_read_hits,
  output logic [CNT_W-1:0]     out_read_misses,
  output logic [CNT_W-1:0]     out_write_hits,
  output logic [CNT_W-1:0]     out_write_misses,
  input  cmd_t                 cmd,
  output stat_t                sts
);

  localparam int LOG_CW = $clog2(CACHE_WORDS);
  localparam int LOG_MB = $clog2(MAX_BLOCK_WORDS);
  localparam int CL_W   = (LOG_CW > 0) ? LOG_CW : 1;
  localparam int BJ_W   = (LOG_MB > 0) ? LOG_MB : 1;
  localparam int MA_W   = $clog2(MEM_WORDS);

  logic [1:0]       mapping_r;
  logic             policy_r;
  logic [3:0]       cwl_r;
  logic [2:0]       bwl_r;
  logic [3:0]       wl_r;

  logic [WORD_BITS-1:0] mem [MEM_WORDS];
  logic [WORD_BITS-1:0] lw_mem [CACHE_WORDS];
  logic [MA_W-1:0]      tag_mem [CACHE_WORDS];
  logic [CL_W-1:0]      fq_mem [CACHE_WORDS];
  logic [CACHE_WORDS-1:0] valid_r;
  logic [CACHE_WORDS-1:0] dirty_r;

  logic [WORD_BITS-1:0] mem_q, lw_q;
  logic [MA_W-1:0]      tag_q;
  logic [CL_W-1:0]      fq_q;

  logic [KIND_W-1:0]    kind_r;
  logic [MA_W-1:0]      addr_r;
  logic [WORD_BITS-1:0] data_r;
  logic [CL_W-1:0]      way_r, line_r, vw_r;
  logic [BJ_W-1:0]      j_r;
  logic                 hit_r, inv_found_r;
  logic [MA_W-1:0]      clr_r;
  logic [CNT_W-1:0]     rh_r, rm_r, wh_r, wm_r;
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_rd_r;
  logic                 out_hit_r;
  logic [CNT_W-1:0]     out_rh_r, out_rm_r, out_wh_r, out_wm_r;

  logic [3:0] lc, lb0, lb, ll, waylog, setslog;
  logic [CL_W-1:0] waymask, setmask, linemask, set_a, first, cur_line, vic_line, set_wb;
  logic [BJ_W-1:0] bmask, off;
  logic [MA_W-1:0] tag_a, fill_addr, wb_addr, blk;
  logic            match;

  always_comb begin
    lc  = (cwl_r > 4'(LOG_CW)) ? 4'(LOG_CW) : cwl_r;
    lb0 = ({1'b0, bwl_r} > 4'(LOG_MB)) ? 4'(LOG_MB) : {1'b0, bwl_r};
    lb  = (lb0 > lc) ? lc : lb0;
    ll  = lc - lb;
    if (mapping_r == MAP_SET) waylog = (wl_r > ll) ? ll : wl_r;
    else if (mapping_r == MAP_FULL) waylog = ll;
    else waylog = 4'd0;
    setslog   = ll - waylog;
    waymask   = ~({CL_W{1'b1}} << waylog);
    setmask   = ~({CL_W{1'b1}} << setslog);
    linemask  = ~({CL_W{1'b1}} << ll);
    bmask     = ~({BJ_W{1'b1}} << lb);
    off       = BJ_W'(addr_r) & bmask;
    set_a     = CL_W'(addr_r >> lb) & setmask;
    tag_a     = addr_r >> (lb + setslog);
    first     = set_a << waylog;
    cur_line  = first | way_r;
    vic_line  = first | (fq_q & waymask);
    set_wb    = (kind_r == KIND_FLUSH) ? (line_r >> waylog) : set_a;
    blk       = (tag_q << setslog) | MA_W'(set_wb);
    wb_addr   = (blk << lb) | MA_W'(j_r);
    fill_addr = (addr_r & ~MA_W'(bmask)) | MA_W'(j_r);
    match     = valid_r[cur_line] && (tag_q == tag_a);
  end

  always_comb begin
    sts.kind      = kind_r;
    sts.wb        = (policy_r == WP_BACK);
    sts.match     = match;
    sts.way_last  = (way_r == waymask);
    sts.inv_any   = inv_found_r || !valid_r[cur_line];
    sts.word_last = (j_r == bmask);
    sts.q_last    = (way_r == waymask - CL_W'(1));
    sts.ways_one  = (waylog == 4'd0);
    sts.dirty_cur = dirty_r[line_r];
    sts.line_last = (line_r == linemask);
    sts.clr_last  = (clr_r == MA_W'(MEM_WORDS - 1));
    sts.out_free  = !out_valid_r || out_tready;
  end

  // Memories with registered read data.
  always_ff @(posedge clk) begin
    if (cmd == CMD_CLR) mem[clr_r] <= '0;
    else if (cmd == CMD_WB_WR) mem[wb_addr] <= lw_q;
    else if (cmd == CMD_ACC && kind_r == KIND_WRITE && policy_r != WP_BACK) mem[addr_r] <= data_r;
    if (cmd == CMD_FILL_RD) mem_q <= mem[fill_addr];

    if (cmd == CMD_FILL_WR) lw_mem[CL_W'(line_r << lb) | CL_W'(j_r)] <= mem_q;
    else if (cmd == CMD_ACC && kind_r == KIND_WRITE) lw_mem[CL_W'(line_r << lb) | CL_W'(off)] <= data_r;
    if (cmd == CMD_WB_RD) lw_q <= lw_mem[CL_W'(line_r << lb) | CL_W'(j_r)];
    else if (cmd == CMD_ACC) lw_q <= lw_mem[CL_W'(line_r << lb) | CL_W'(off)];

    if (cmd == CMD_SET_LINE) tag_mem[line_r] <= tag_a;
    if (cmd == CMD_TAG_RD) tag_q <= tag_mem[cur_line];
    else if (cmd == CMD_VICTIM) tag_q <= tag_mem[vic_line];
    else if (cmd == CMD_FL_CHK) tag_q <= tag_mem[line_r];

    if (cmd == CMD_FQ_WR) fq_mem[first | way_r] <= fq_q;
    else if (cmd == CMD_FQ_LAST) fq_mem[first | waymask] <= vw_r;
    if (cmd == CMD_FIFO_RD) fq_q <= fq_mem[first];
    else if (cmd == CMD_FQ_RD) fq_q <= fq_mem[first | (way_r + CL_W'(1))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapping_r   <= '0;
      policy_r    <= '0;
      cwl_r       <= 4'd8;
      bwl_r       <= 3'd2;
      wl_r        <= 4'd1;
      valid_r     <= '0;
      dirty_r     <= '0;
      clr_r       <= '0;
      rh_r        <= '0;
      rm_r        <= '0;
      wh_r        <= '0;
      wm_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAPPING: mapping_r <= cfg_wdata[1:0];
          CFG_POLICY:  policy_r  <= cfg_wdata[0];
          CFG_CACHE:   cwl_r     <= cfg_wdata;
          CFG_BLOCK:   bwl_r     <= cfg_wdata[2:0];
          CFG_WAYS:    wl_r      <= cfg_wdata;
          default: ;
        endcase
        if (cfg_index <= CFG_WAYS) begin
          valid_r <= '0;
          dirty_r <= '0;
        end
      end
      if (cmd == CMD_RESULT) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (cmd)
        CMD_CLR:      clr_r <= clr_r + MA_W'(1);
        CMD_VICTIM:   valid_r[vic_line] <= 1'b0;
        CMD_SET_LINE: begin
          valid_r[line_r] <= 1'b1;
          dirty_r[line_r] <= 1'b0;
        end
        CMD_INV:      valid_r <= '0;
        CMD_ACC: begin
          if (kind_r == KIND_WRITE) begin
            dirty_r[line_r] <= 1'b1;
            if (hit_r) wh_r <= wh_r + CNT_W'(1);
            else wm_r <= wm_r + CNT_W'(1);
          end else begin
            if (hit_r) rh_r <= rh_r + CNT_W'(1);
            else rm_r <= rm_r + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        kind_r      <= in_kind;
        addr_r      <= MA_W'(in_address);
        data_r      <= in_write_data;
        way_r       <= '0;
        line_r      <= '0;
        j_r         <= '0;
        hit_r       <= 1'b0;
        inv_found_r <= 1'b0;
      end
      CMD_TAG_CMP: begin
        if (match) begin
          line_r <= cur_line;
          hit_r  <= 1'b1;
        end else if (!inv_found_r && !valid_r[cur_line]) begin
          inv_found_r <= 1'b1;
          vw_r        <= way_r;
          line_r      <= cur_line;
        end
        way_r <= way_r + CL_W'(1);
      end
      CMD_VICTIM: begin
        vw_r   <= fq_q & waymask;
        line_r <= vic_line;
        j_r    <= '0;
      end
      CMD_WB_WR, CMD_FILL_WR: j_r <= (j_r == bmask) ? '0 : j_r + BJ_W'(1);
      CMD_SET_LINE: way_r <= '0;
      CMD_FQ_WR:    way_r <= way_r + CL_W'(1);
      CMD_FL_NEXT:  line_r <= line_r + CL_W'(1);
      CMD_RESULT: begin
        out_rd_r  <= (kind_r == KIND_READ) ? lw_q : '0;
        out_hit_r <= hit_r && !kind_r[1];
        out_rh_r  <= rh_r;
        out_rm_r  <= rm_r;
        out_wh_r  <= wh_r;
        out_wm_r  <= wm_r;
      end
      default: ;
    endcase
  end

  assign out_tvalid       = out_valid_r;
  assign out_read_data    = out_rd_r;
  assign out_hit          = out_hit_r;
  assign out_read_hits    = out_rh_r;
  assign out_read_misses  = out_rm_r;
  assign out_write_hits   = out_wh_r;
  assign out_write_misses = out_wm_r;

  a_hit_only_rw: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_RESULT && kind_r[1]) |=> !out_hit_r)
    else $error("hit reported for flush or invalidate");

  a_line_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_SET_LINE && !cfg_we) |=> valid_r[$past(line_r)])
    else $error("filled line not valid");

  a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd != CMD_ACC |=> ($stable(rh_r) && $stable(rm_r) && $stable(wh_r) && $stable(wm_r)))
    else $error("counter moved outside an access");

endmodule

// File: hdl/configurable_cache_fifo_writepolicy.sv
// Top level of the word-addressed cache with FIFO replacement and backing memory.
// Requests enter on the in_ stream: in_tuser carries the kind (read, write, flush,
// invalidate all), in_tdata the word address and the write word. Each request
// gives one result on the out_ stream: read word, hit flag and four wrapping
// hit and miss counters. Geometry and write policy are set through the cfg_
// write port; the user must write it only while the block is idle, which the
// block itself does not enforce. Any write with cfg_index up to CFG_WAYS clears all
// valid and dirty bits. One request is worked at a time. Lookup walks the ways
// of the set; a hit then passes the access and result states until out_tvalid
// rises, and in_tready rises with it. A miss adds the fill of each block word,
// the write-back of each block word under write-back policy, the victim pick
// when the set is full, and a step per way to advance the set's FIFO queue.
// Under write-back policy a flush walks every line with a block write-back for
// each dirty line; under write-through it walks no line. The tag, line and
// memory arrays are single-port. After reset all MEM_WORDS words (4096 by
// default) of the backing memory are cleared one word a cycle, with in_tready
// low. The result waits in an output register while out_tready is low; the block
// can take the next request meanwhile but not finish it until the result is taken.
module configurable_cache_fifo_writepolicy
  import ccfw_pkg::*;
#(
  parameter int CACHE_WORDS     = CACHE_WORDS_DEF,
  parameter int MEM_WORDS       = MEM_WORDS_DEF,
  parameter int MAX_BLOCK_WORDS = MAX_BLOCK_WORDS_DEF,
  parameter int WORD_BITS       = WORD_BITS_DEF,
  localparam int IN_TD_W  = ((ADDR_W + WORD_BITS + 7) / 8) * 8,
  localparam int OUT_TD_W = ((WORD_BITS + 1 + 4 * CNT_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_I_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_TD_W-1:0]   in_tdata,   // address, write_data
  input  logic [KIND_W-1:0]    in_tuser,   // kind
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_TD_W-1:0]  out_tdata   // read_data, hit, read_hits, read_misses,
                                           // write_hits, write_misses
);

  cmd_t  cmd;
  stat_t sts;

  logic [WORD_BITS-1:0] rd;
  logic                 hit;
  logic [CNT_W-1:0]     rh, rm, wh, wm;

  ccfw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ccfw_dp #(
    .CACHE_WORDS     (CACHE_WORDS),
    .MEM_WORDS       (MEM_WORDS),
    .MAX_BLOCK_WORDS (MAX_BLOCK_WORDS),
    .WORD_BITS       (WORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_kind          (in_tuser),
    .in_address       (in_tdata[ADDR_W-1:0]),
    .in_write_data    (in_tdata[ADDR_W +: WORD_BITS]),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .out_read_data    (rd),
    .out_hit          (hit),
    .out_read_hits    (rh),
    .out_read_misses  (rm),
    .out_write_hits   (wh),
    .out_write_misses (wm),
    .cmd              (cmd),
    .sts              (sts)
  );

  assign out_tdata = OUT_TD_W'({wm, wh, rm, rh, hit, rd});

endmodule
